// ----- rtl/core/sdsch_pkg.sv -----
// ----------------------------------------------------------------------------
// sdsch_pkg
// Shared types and constants of the SCAN disk scheduler.
// ----------------------------------------------------------------------------
package sdsch_pkg;

  localparam int unsigned MAX_REQUESTS_DEF = 8;
  localparam logic [16:0] TRACK_COUNT_RST  = 17'd200;

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned TRACK_W = 16;
  localparam int unsigned SEEK_W  = 17;

  // input kind codes
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_START = 1'b1;

  // classified command: value is the track for a load, the head for a start
  typedef struct packed {
    logic                 start;
    logic [TRACK_W-1:0]   value;
    logic                 dir_up;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE
  } state_t;

endpackage

// ----- rtl/core/sdsch_front.sv -----
// ----------------------------------------------------------------------------
// sdsch_front
// Accepts input transactions, classifies them into load or start commands
// and queues them for the scan engine.
// ----------------------------------------------------------------------------
module sdsch_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [sdsch_pkg::TRACK_W-1:0] in_track,
  input  logic [sdsch_pkg::TRACK_W-1:0] in_head,
  input  logic                          in_direction_up,
  output sdsch_pkg::cmd_t               cmd,
  output logic                          cmd_valid,
  input  logic                          cmd_pop
);

  sdsch_pkg::cmd_t                   fifo_q [sdsch_pkg::QUEUE_DEPTH];
  logic [sdsch_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [sdsch_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [sdsch_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;
  sdsch_pkg::cmd_t                   new_cmd;
  logic                              push;
  logic                              pop;

  assign in_stall  = (cnt_r == sdsch_pkg::QCNT_W'(sdsch_pkg::QUEUE_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = fifo_q[rd_ptr_r];
  assign push      = in_valid && !in_stall;
  assign pop       = cmd_pop && cmd_valid;

  always_comb begin
    new_cmd.start  = (in_kind == sdsch_pkg::KIND_START);
    new_cmd.value  = new_cmd.start ? in_head : in_track;
    new_cmd.dir_up = in_direction_up;
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_q[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

// ----- rtl/core/sdsch_back.sv -----
// ----------------------------------------------------------------------------
// sdsch_back
// Request store and scan engine. Each visit is found by one pass over the
// store that picks the next (track, slot) key in sweep order; a found visit
// is held back one step so the final one can carry the last mark.
// ----------------------------------------------------------------------------
module sdsch_back #(
  parameter int unsigned MAX_REQUESTS = sdsch_pkg::MAX_REQUESTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [16:0]                   track_count,
  input  sdsch_pkg::cmd_t               cmd,
  input  logic                          cmd_valid,
  output logic                          cmd_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sdsch_pkg::TRACK_W-1:0] out_visited_track,
  output logic [sdsch_pkg::SEEK_W-1:0]  out_seek_total,
  output logic                          out_last,
  output logic                          busy
);

  localparam int unsigned CW = $clog2(MAX_REQUESTS + 2);
  localparam int unsigned AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int unsigned TW = sdsch_pkg::TRACK_W;
  localparam int unsigned SW = sdsch_pkg::SEEK_W;
  localparam int unsigned KW = TW + CW;

  logic [TW-1:0]       mem [MAX_REQUESTS];
  logic [TW-1:0]       rd_data_r;
  logic [AW-1:0]       rd_addr;
  logic                mem_we;

  sdsch_pkg::state_t   state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       sc_r, sc_nxt;
  logic [TW-1:0]       head_r, head_nxt;
  logic                up_r, up_nxt;
  logic                phase_r, phase_nxt;
  logic [TW-1:0]       last_trk_r, last_trk_nxt;
  logic                have_prev_r, have_prev_nxt;
  logic [KW-1:0]       prev_key_r, prev_key_nxt;
  logic                found_r, found_nxt;
  logic [KW-1:0]       best_key_r, best_key_nxt;
  logic                have_pend_r, have_pend_nxt;
  logic [TW-1:0]       pend_trk_r, pend_trk_nxt;
  logic [SW-1:0]       pend_tot_r, pend_tot_nxt;
  logic [TW-1:0]       pos_r, pos_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [TW-1:0]       out_trk_r, out_trk_nxt;
  logic [SW-1:0]       out_tot_r, out_tot_nxt;
  logic                out_last_r, out_last_nxt;

  logic [16:0]         tc_m1;
  logic [TW-1:0]       last_trk_calc;
  logic                cmp_valid;
  logic [CW-1:0]       cmp_idx;
  logic                cmp_virtual;
  logic [TW-1:0]       cmp_val;
  logic [KW-1:0]       cmp_key;
  logic                asc;
  logic                in_group;
  logic                after_prev;
  logic                better;
  logic                take;
  logic                scan_end;
  logic                out_free;
  logic                need_emit;
  logic                emit_block;
  logic [TW-1:0]       best_val;
  logic [TW-1:0]       seek_dist;
  logic [SW-1:0]       base_tot;
  logic [SW:0]         sum_tot;

  // ---- decode -------------------------------------------------------------
  assign tc_m1         = track_count - 17'd1;
  assign last_trk_calc = (track_count == '0) ? '0 :
                         tc_m1[16] ? {TW{1'b1}} : tc_m1[TW-1:0];

  assign cmd_pop  = (state_r == sdsch_pkg::ST_IDLE) && cmd_valid;
  assign mem_we   = cmd_pop && !cmd.start && (count_r < CW'(MAX_REQUESTS));
  assign rd_addr  = (sc_r < count_r) ? sc_r[AW-1:0] : '0;

  // compare stage works on the entry registered from the store in the previous cycle
  assign cmp_valid   = (state_r == sdsch_pkg::ST_SCAN) && (sc_r != '0);
  assign cmp_idx     = sc_r - 1'b1;
  assign cmp_virtual = (cmp_idx == count_r);
  assign cmp_val     = cmp_virtual ? (up_r ? last_trk_r : '0) : rd_data_r;
  assign cmp_key     = {cmp_val, cmp_idx};
  assign asc         = up_r ^ phase_r;
  // end track only belongs to the first sweep, and joins it wherever it lies
  assign in_group    = cmp_virtual ? !phase_r :
                       asc ? (cmp_val > head_r) : (cmp_val < head_r);
  assign after_prev  = !have_prev_r ||
                       (asc ? (cmp_key > prev_key_r) : (cmp_key < prev_key_r));
  assign better      = !found_r ||
                       (asc ? (cmp_key < best_key_r) : (cmp_key > best_key_r));
  assign take        = cmp_valid && in_group && after_prev && better;
  assign scan_end    = (sc_r == count_r + 1'b1);

  assign out_free    = !out_valid_r || !out_stall;
  assign need_emit   = found_r ? have_pend_r : phase_r;
  assign emit_block  = need_emit && !out_free;

  assign best_val    = best_key_r[KW-1 -: TW];
  assign seek_dist   = (best_val > pos_r) ? best_val - pos_r : pos_r - best_val;
  assign base_tot    = have_pend_r ? pend_tot_r : '0;
  assign sum_tot     = {1'b0, base_tot} + (SW + 1)'(seek_dist);

  // ---- next state ---------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sdsch_pkg::ST_IDLE: begin
        if (cmd_valid && cmd.start) begin
          state_nxt = sdsch_pkg::ST_SCAN;
        end
      end
      sdsch_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_nxt = sdsch_pkg::ST_RESOLVE;
        end
      end
      sdsch_pkg::ST_RESOLVE: begin
        if (!emit_block) begin
          state_nxt = (!found_r && phase_r) ? sdsch_pkg::ST_IDLE : sdsch_pkg::ST_SCAN;
        end
      end
      default: state_nxt = sdsch_pkg::ST_IDLE;
    endcase
  end

  // ---- datapath and outputs -----------------------------------------------
  always_comb begin
    count_nxt     = count_r;
    sc_nxt        = sc_r;
    head_nxt      = head_r;
    up_nxt        = up_r;
    phase_nxt     = phase_r;
    last_trk_nxt  = last_trk_r;
    have_prev_nxt = have_prev_r;
    prev_key_nxt  = prev_key_r;
    found_nxt     = found_r;
    best_key_nxt  = best_key_r;
    have_pend_nxt = have_pend_r;
    pend_trk_nxt  = pend_trk_r;
    pend_tot_nxt  = pend_tot_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_trk_nxt   = out_trk_r;
    out_tot_nxt   = out_tot_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      sdsch_pkg::ST_IDLE: begin
        if (cmd_pop) begin
          if (!cmd.start) begin
            if (mem_we) begin
              count_nxt = count_r + 1'b1;
            end
          end else begin
            head_nxt      = cmd.value;
            pos_nxt       = cmd.value;
            up_nxt        = cmd.dir_up;
            last_trk_nxt  = last_trk_calc;
            phase_nxt     = 1'b0;
            have_prev_nxt = 1'b0;
            have_pend_nxt = 1'b0;
            found_nxt     = 1'b0;
            sc_nxt        = '0;
          end
        end
      end
      sdsch_pkg::ST_SCAN: begin
        if (!scan_end) begin
          sc_nxt = sc_r + 1'b1;
        end
        if (take) begin
          found_nxt    = 1'b1;
          best_key_nxt = cmp_key;
        end
      end
      sdsch_pkg::ST_RESOLVE: begin
        if (!emit_block) begin
          if (need_emit) begin
            out_valid_nxt = 1'b1;
            out_trk_nxt   = pend_trk_r;
            out_tot_nxt   = pend_tot_r;
            out_last_nxt  = !found_r;
          end
          sc_nxt    = '0;
          found_nxt = 1'b0;
          if (found_r) begin
            pend_trk_nxt  = best_val;
            pend_tot_nxt  = sum_tot[SW] ? {SW{1'b1}} : sum_tot[SW-1:0];
            pos_nxt       = best_val;
            prev_key_nxt  = best_key_r;
            have_prev_nxt = 1'b1;
            have_pend_nxt = 1'b1;
          end else if (!phase_r) begin
            phase_nxt     = 1'b1;
            have_prev_nxt = 1'b0;
          end else begin
            count_nxt = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sdsch_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sc_r        <= sc_nxt;
    head_r      <= head_nxt;
    up_r        <= up_nxt;
    phase_r     <= phase_nxt;
    last_trk_r  <= last_trk_nxt;
    have_prev_r <= have_prev_nxt;
    prev_key_r  <= prev_key_nxt;
    found_r     <= found_nxt;
    best_key_r  <= best_key_nxt;
    have_pend_r <= have_pend_nxt;
    pend_trk_r  <= pend_trk_nxt;
    pend_tot_r  <= pend_tot_nxt;
    pos_r       <= pos_nxt;
    out_trk_r   <= out_trk_nxt;
    out_tot_r   <= out_tot_nxt;
    out_last_r  <= out_last_nxt;
  end

  // request store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[AW-1:0]] <= cmd.value;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_valid         = out_valid_r;
  assign out_visited_track = out_trk_r;
  assign out_seek_total    = out_tot_r;
  assign out_last          = out_last_r;
  assign busy              = (state_r != sdsch_pkg::ST_IDLE);

endmodule

// ----- rtl/core/scan_disk_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// scan_disk_scheduler_unit
// SCAN (elevator) disk scheduler: stores track requests and emits the visit
// order with running seek totals when a scan is started.
// ----------------------------------------------------------------------------
// Load transactions queue pending requests (up to MAX_REQUESTS, extras are
// dropped); a start transaction gives the head and first direction and the
// block emits one result per visited track, the end track included, with
// last set on the final one, then empties the store. A two-entry command
// queue decouples the input from the scan engine. A start makes one pass
// over the request store per visit plus one closing pass per sweep; a
// stalled result holds the engine. track_count is written through
// cfg_we/cfg_wdata; the user must write it only while idle, which the block
// itself does not enforce.
module scan_disk_scheduler_unit #(
  parameter int unsigned MAX_REQUESTS = sdsch_pkg::MAX_REQUESTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [16:0]                   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [sdsch_pkg::TRACK_W-1:0] in_track,
  input  logic [sdsch_pkg::TRACK_W-1:0] in_head,
  input  logic                          in_direction_up,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sdsch_pkg::TRACK_W-1:0] out_visited_track,
  output logic [sdsch_pkg::SEEK_W-1:0]  out_seek_total,
  output logic                          out_last
);

  logic [16:0]     track_count_r, track_count_nxt;
  sdsch_pkg::cmd_t cmd;
  logic            cmd_valid;
  logic            cmd_pop;
  logic            busy;

  assign track_count_nxt = cfg_we ? cfg_wdata : track_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_count_r <= sdsch_pkg::TRACK_COUNT_RST;
    end else begin
      track_count_r <= track_count_nxt;
    end
  end

  sdsch_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_track        (in_track),
    .in_head         (in_head),
    .in_direction_up (in_direction_up),
    .cmd             (cmd),
    .cmd_valid       (cmd_valid),
    .cmd_pop         (cmd_pop)
  );

  sdsch_back #(
    .MAX_REQUESTS (MAX_REQUESTS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .track_count       (track_count_r),
    .cmd               (cmd),
    .cmd_valid         (cmd_valid),
    .cmd_pop           (cmd_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_visited_track (out_visited_track),
    .out_seek_total    (out_seek_total),
    .out_last          (out_last),
    .busy              (busy)
  );

`ifndef SYNTHESIS
  // a stalled result holds still until it is taken
  a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid &&
      $stable({out_visited_track, out_seek_total, out_last}))
    else $error("stalled result changed");

  // results only come out of a running scan
  a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(busy))
    else $error("result appeared while engine idle");

  // a non-final visit means the scan is still in progress
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |-> busy)
    else $error("engine idle at non-final visit");
`endif

endmodule
